### design/ssrg_pkg.sv
// ----------------------------------------------------------------------------
// ssrg_pkg
// Shared types and constants for the stepper step rate generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrg_pkg;

   localparam int MAX_SPEED_DEFAULT = 1000;
   localparam int SPEED_W           = 10;
   localparam int DATA_W            = 32;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd1000;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_ADD  = 2'd1,
      OP_STOP = 2'd2,
      OP_CONT = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_DIV  = 1'b1
   } state_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

### design/ssrg_div.sv
// ----------------------------------------------------------------------------
// ssrg_div
// Restoring divider, one quotient bit per cycle: MAX_SPEED / divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrg_div #(
   parameter int MAX_SPEED = ssrg_pkg::MAX_SPEED_DEFAULT,
   parameter int QW        = $clog2(MAX_SPEED + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ssrg_pkg::SPEED_W-1:0] divisor,
   output logic      [QW-1:0]                quotient,
   output ssrg_pkg::div_stat_type            stat
);

   localparam int CW = (QW > 1) ? $clog2(QW) : 1;
   localparam logic [QW-1:0] DIVIDEND = QW'(MAX_SPEED);
   localparam logic [CW-1:0] LAST_CNT = CW'(QW - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [ssrg_pkg::SPEED_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]                quo_ff, quo_in;

   logic [ssrg_pkg::SPEED_W:0]   trial;
   logic                         fits;
   logic [QW:0]                  shifted;

   always_comb begin
      trial   = {rem_ff, quo_ff[QW-1]};
      fits    = (trial >= {1'b0, divisor});
      shifted = {quo_ff, fits};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_CNT;
         rem_in  = '0;
         quo_in  = DIVIDEND;
      end else if (busy_ff) begin
         rem_in = fits ? ssrg_pkg::SPEED_W'(trial - {1'b0, divisor})
                       : trial[ssrg_pkg::SPEED_W-1:0];
         quo_in = shifted[QW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

### design/stepper_step_rate_generator.sv
// Timing: a command, or a tick that cannot run, has its result registered on
//   acceptance; a running tick first runs the bit-serial divide of MAX_SPEED / speed
//   (QW = clog2(MAX_SPEED+1) = 10 bits at 1000), then registers its result.
// Throughput: one item at a time; commands can go every cycle, a running tick holds
//   the input through its divide; the output register must be free or emptying.
// Reset: synchronous; speed returns to 1000, counters, budget and mode clear.
// ----------------------------------------------------------------------------
// stepper_step_rate_generator
// Turns base-rate ticks into step pulses, with on-demand budget and
// continuous mode.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_step_rate_generator #(
   parameter int MAX_SPEED = ssrg_pkg::MAX_SPEED_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_op,
   input  wire logic [ssrg_pkg::DATA_W-1:0]   req_step_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_step_pulse,
   output logic      [ssrg_pkg::DATA_W-1:0]   rsp_steps_taken,
   output logic      [ssrg_pkg::DATA_W-1:0]   rsp_steps_remaining,
   output logic                               rsp_continuous,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ssrg_pkg::SPEED_W-1:0]  csr_data
);

   localparam int QW = $clog2(MAX_SPEED + 1);
   localparam int DW = ssrg_pkg::DATA_W;

   ssrg_pkg::state_type    state_ff, state_in;
   logic [ssrg_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [QW-1:0]          phase_ff, phase_in;
   logic [DW-1:0]          total_ff, total_in;
   logic [DW-1:0]          budget_ff, budget_in;
   logic                   cont_ff, cont_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pulse_ff, rsp_pulse_in;
   logic [DW-1:0]          rsp_total_ff, rsp_total_in;
   logic [DW-1:0]          rsp_budget_ff, rsp_budget_in;
   logic                   rsp_cont_ff, rsp_cont_in;

   logic                   accept;
   logic                   csr_write;
   logic                   load_rsp;
   logic                   div_start;
   logic [QW-1:0]          quotient;
   logic [QW-1:0]          div_val;
   logic [QW:0]            phase_inc;
   logic [DW:0]            add_sum;
   logic [DW-1:0]          add_base;
   logic                   can_run;
   ssrg_pkg::op_type       op;
   ssrg_pkg::div_stat_type div_stat;

   ssrg_div #(
      .MAX_SPEED (MAX_SPEED),
      .QW        (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (speed_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign op        = ssrg_pkg::op_type'(req_op);
   assign req_stall = (state_ff != ssrg_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = (state_ff == ssrg_pkg::ST_IDLE);
   assign csr_write = csr_valid && csr_ready;
   assign can_run   = (speed_ff != '0) && (cont_ff || (budget_ff != '0));

   always_comb begin
      state_in      = state_ff;
      speed_in      = speed_ff;
      phase_in      = phase_ff;
      total_in      = total_ff;
      budget_in     = budget_ff;
      cont_in       = cont_ff;
      div_start     = 1'b0;
      load_rsp      = 1'b0;
      rsp_pulse_in  = 1'b0;
      // quotient of zero means speed above MAX_SPEED: step every tick
      div_val       = (quotient == '0) ? QW'(1) : quotient;
      phase_inc     = {1'b0, phase_ff} + 1'b1;
      add_base      = cont_ff ? '0 : budget_ff;
      add_sum       = {1'b0, add_base} + {1'b0, req_step_count};

      case (state_ff)
         ssrg_pkg::ST_IDLE: begin
            if (accept) begin
               case (op)
                  ssrg_pkg::OP_TICK: begin
                     if (can_run) begin
                        div_start = 1'b1;
                        state_in  = ssrg_pkg::ST_DIV;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  ssrg_pkg::OP_ADD: begin
                     cont_in   = 1'b0;
                     budget_in = add_sum[DW] ? '1 : add_sum[DW-1:0];
                     load_rsp  = 1'b1;
                  end
                  ssrg_pkg::OP_STOP: begin
                     cont_in   = 1'b0;
                     budget_in = '0;
                     load_rsp  = 1'b1;
                  end
                  ssrg_pkg::OP_CONT: begin
                     cont_in   = 1'b1;
                     budget_in = '0;
                     load_rsp  = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ssrg_pkg::ST_DIV: begin
            if (div_stat.done) begin
               load_rsp = 1'b1;
               state_in = ssrg_pkg::ST_IDLE;
               if (phase_ff == '0) begin
                  rsp_pulse_in = 1'b1;
                  total_in     = total_ff + 1'b1;
                  if (!cont_ff) begin
                     budget_in = budget_ff - 1'b1;
                  end
               end
               phase_in = (phase_inc >= {1'b0, div_val}) ? '0 : phase_inc[QW-1:0];
            end
         end
         default: begin
            state_in = ssrg_pkg::ST_IDLE;
         end
      endcase

      if (csr_write) begin
         speed_in = csr_data;
         phase_in = '0;
      end

      rsp_total_in  = total_in;
      rsp_budget_in = budget_in;
      rsp_cont_in   = cont_in;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssrg_pkg::ST_IDLE;
         speed_ff     <= ssrg_pkg::SPEED_RESET;
         phase_ff     <= '0;
         total_ff     <= '0;
         budget_ff    <= '0;
         cont_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         budget_ff    <= budget_in;
         cont_ff      <= cont_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pulse_ff  <= rsp_pulse_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_budget_ff <= rsp_budget_in;
         rsp_cont_ff   <= rsp_cont_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_pulse      = rsp_pulse_ff;
   assign rsp_steps_taken     = rsp_total_ff;
   assign rsp_steps_remaining = rsp_budget_ff;
   assign rsp_continuous      = rsp_cont_ff;

   // continuous mode never carries a budget
   a_cont_no_budget: assert property (@(posedge clock) disable iff (reset)
      cont_ff |-> (budget_ff == '0))
      else $error("budget nonzero in continuous mode");

   // while dividing, the output slot is empty and the divider is active
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssrg_pkg::ST_DIV) |-> (!rsp_valid_ff && (div_stat.busy || div_stat.done)))
      else $error("divide state without divider activity");

   // a step pulse advances the running total by one
   a_pulse_count: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && rsp_pulse_in) |=> (total_ff == $past(total_ff) + 1'b1))
      else $error("step total did not advance with pulse");

   // the divider is only started from idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == ssrg_pkg::ST_IDLE && !div_stat.busy))
      else $error("divider restarted while busy");

endmodule

`default_nettype wire

### tb/stepper_step_rate_generator_tb.sv
// ----------------------------------------------------------------------------
// stepper_step_rate_generator_tb
// Self-checking bench: a queue-fed driver sends tick and budget commands,
// a per-item predictor tracks phase, budget, mode and step total, and a
// monitor compares every returned status item against the prediction.
// ----------------------------------------------------------------------------

module stepper_step_rate_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SPEED = ssrg_pkg::MAX_SPEED_DEFAULT;

   typedef struct packed {
      ssrg_pkg::op_type                op;
      logic [ssrg_pkg::DATA_W-1:0]     count;
   } stepper_cmd_type;

   typedef struct packed {
      logic                            pulse;
      logic [ssrg_pkg::DATA_W-1:0]     taken;
      logic [ssrg_pkg::DATA_W-1:0]     remaining;
      logic                            cont;
   } stepper_status_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [1:0]                         req_op = ssrg_pkg::OP_TICK;
   logic [ssrg_pkg::DATA_W-1:0]        req_step_count = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_step_pulse;
   logic [ssrg_pkg::DATA_W-1:0]        rsp_steps_taken;
   logic [ssrg_pkg::DATA_W-1:0]        rsp_steps_remaining;
   logic                               rsp_continuous;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ssrg_pkg::SPEED_W-1:0]       csr_data = '0;

   // predictor state
   logic [ssrg_pkg::SPEED_W-1:0]       speed_cfg = ssrg_pkg::SPEED_RESET;
   logic [ssrg_pkg::SPEED_W-1:0]       phase_cnt = '0;
   logic [ssrg_pkg::DATA_W-1:0]        step_total = '0;
   logic [ssrg_pkg::DATA_W-1:0]        budget = '0;
   logic                               mode_cont = 1'b0;

   stepper_cmd_type                    cmd_queue[$];
   stepper_status_type                 predicted_status[$];
   int                                 send_idle_pct = 0;
   int                                 recv_stall_pct = 0;
   bit                                 send_hold = 1'b0;
   bit                                 req_fired = 1'b0;
   int                                 fail_count = 0;

   stepper_step_rate_generator #(
      .MAX_SPEED (MAX_SPEED)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_step_count      (req_step_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_steps_taken     (rsp_steps_taken),
      .rsp_steps_remaining (rsp_steps_remaining),
      .rsp_continuous      (rsp_continuous),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic stepper_status_type advance_stepper(
      ssrg_pkg::op_type op, logic [ssrg_pkg::DATA_W-1:0] cnt);
      stepper_status_type res;
      int div;
      res.pulse = 1'b0;
      case (op)
         ssrg_pkg::OP_TICK: begin
            if (speed_cfg != 0 && (mode_cont || budget != 0)) begin
               div = MAX_SPEED / int'(speed_cfg);
               if (div == 0) div = 1;
               if (phase_cnt == 0) begin
                  res.pulse = 1'b1;
                  step_total = step_total + 1;
                  if (!mode_cont) budget = budget - 1;
               end
               if (int'(phase_cnt) + 1 >= div) phase_cnt = '0;
               else phase_cnt = phase_cnt + 1;
            end
         end
         ssrg_pkg::OP_ADD: begin
            if (mode_cont) begin
               mode_cont = 1'b0;
               budget = '0;
            end
            if (cnt > ~budget) budget = '1;
            else budget = budget + cnt;
         end
         ssrg_pkg::OP_STOP: begin
            mode_cont = 1'b0;
            budget = '0;
         end
         default: begin
            mode_cont = 1'b1;
            budget = '0;
         end
      endcase
      res.taken = step_total;
      res.remaining = budget;
      res.cont = mode_cont;
      return res;
   endfunction

   function automatic logic [ssrg_pkg::DATA_W-1:0] pick_count();
      case ($urandom_range(9))
         6:       return $urandom;
         7:       return '1;
         8:       return '1 - $urandom_range(3);
         9:       return $urandom_range(100);
         default: return $urandom_range(8);
      endcase
   endfunction

   function automatic stepper_cmd_type pick_cmd();
      stepper_cmd_type c;
      int r;
      r = $urandom_range(99);
      if (r < 68) c.op = ssrg_pkg::OP_TICK;
      else if (r < 82) c.op = ssrg_pkg::OP_ADD;
      else if (r < 88) c.op = ssrg_pkg::OP_STOP;
      else c.op = ssrg_pkg::OP_CONT;
      c.count = pick_count();
      return c;
   endfunction

   task automatic queue_cmd(ssrg_pkg::op_type op, logic [ssrg_pkg::DATA_W-1:0] cnt);
      stepper_cmd_type c;
      c.op = op;
      c.count = cnt;
      cmd_queue.push_back(c);
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || predicted_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_speed(logic [ssrg_pkg::SPEED_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      speed_cfg = value;
      phase_cnt = '0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // accept side: prediction happens on the edge the item is taken
   always @(posedge clock) begin
      req_fired = !reset && req_valid && !req_stall;
      if (req_fired) begin
         predicted_status.push_back(advance_stepper(ssrg_pkg::op_type'(req_op),
                                                    req_step_count));
         void'(cmd_queue.pop_front());
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // stalled item holds
      end else if (cmd_queue.size() != 0 && !send_hold &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_op <= cmd_queue[0].op;
         req_step_count <= cmd_queue[0].count;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      stepper_status_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_status.size() == 0) begin
            $error("unexpected status item");
            fail_count++;
         end else begin
            exp_s = predicted_status.pop_front();
            if (rsp_step_pulse !== exp_s.pulse) begin
               $error("step_pulse: expected %0d, got %0d", exp_s.pulse, rsp_step_pulse);
               fail_count++;
            end
            if (rsp_steps_taken !== exp_s.taken) begin
               $error("steps_taken: expected %0d, got %0d", exp_s.taken, rsp_steps_taken);
               fail_count++;
            end
            if (rsp_steps_remaining !== exp_s.remaining) begin
               $error("steps_remaining: expected %0d, got %0d",
                      exp_s.remaining, rsp_steps_remaining);
               fail_count++;
            end
            if (rsp_continuous !== exp_s.cont) begin
               $error("continuous: expected %0d, got %0d", exp_s.cont, rsp_continuous);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic [ssrg_pkg::SPEED_W-1:0] spd;
      int n_items;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 6;
      recv_stall_pct = 80;

      // directed, at the reset speed (divisor 1)
      queue_cmd(ssrg_pkg::OP_TICK, '0);             // empty budget
      queue_cmd(ssrg_pkg::OP_ADD, 32'd3);
      repeat (4) queue_cmd(ssrg_pkg::OP_TICK, '1);  // last one runs dry
      queue_cmd(ssrg_pkg::OP_ADD, '0);
      queue_cmd(ssrg_pkg::OP_ADD, '1);
      queue_cmd(ssrg_pkg::OP_ADD, 32'd5);           // saturates
      queue_cmd(ssrg_pkg::OP_TICK, '0);
      queue_cmd(ssrg_pkg::OP_STOP, '1);
      queue_cmd(ssrg_pkg::OP_TICK, '0);
      queue_cmd(ssrg_pkg::OP_CONT, '0);
      queue_cmd(ssrg_pkg::OP_TICK, '0);
      queue_cmd(ssrg_pkg::OP_TICK, '0);
      queue_cmd(ssrg_pkg::OP_CONT, '1);             // already continuous
      queue_cmd(ssrg_pkg::OP_ADD, 32'd2);           // leaves continuous mode
      repeat (3) queue_cmd(ssrg_pkg::OP_TICK, '0);
      queue_cmd(ssrg_pkg::OP_ADD, 32'hAAAA_AAAA);
      queue_cmd(ssrg_pkg::OP_ADD, 32'h5555_5555);   // lands exactly on all ones
      queue_cmd(ssrg_pkg::OP_ADD, 32'd1);
      queue_cmd(ssrg_pkg::OP_STOP, '0);
      wait_drained();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph / 4)
            0: begin send_idle_pct = 6;  recv_stall_pct = 80; end
            1: begin send_idle_pct = 80; recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         case (ph)
            0: spd = 10'd0;
            1: spd = 10'd1023;
            2: spd = 10'd1;
            3: spd = 10'd7;
            4: spd = 10'd250;
            5: spd = 10'd999;
            6: spd = 10'd1000;
            7: spd = 10'd501;
            default: spd = ($urandom_range(9) < 7) ? 10'($urandom_range(1023, 100))
                                                   : 10'($urandom_range(1023));
         endcase
         write_speed(spd);
         n_items = 117;
         for (int i = 0; i < n_items; i++) cmd_queue.push_back(pick_cmd());
         if (ph == 5) begin
            // hold the sender until every result is back
            while (cmd_queue.size() > n_items / 2) @(posedge clock);
            send_hold = 1'b1;
            while (predicted_status.size() != 0) @(posedge clock);
            repeat (5) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
